// ----- rtl/ecdd_pkg.sv -----
// ----------------------------------------------------------------------------
// ecdd_pkg: shared types and constants of the event counter display driver
// Beat types, configuration register indexes, digit positions and the
// seven-segment glyph table.
// ----------------------------------------------------------------------------
package ecdd_pkg;

    // Field widths
    localparam int unsigned PULSE_W   = 4;
    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned LIMIT_W   = 10;
    localparam int unsigned TICKS_W   = 8;
    localparam int unsigned SEG_W     = 7;
    localparam int unsigned SEL_W     = 3;
    localparam int unsigned DIGIT_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // Largest value the three digits can show
    localparam logic [VALUE_W-1:0] DISPLAY_MAX = 16'd999;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_COUNT    = 2'd0,
        CFG_COUNT_LIMIT    = 2'd1,
        CFG_SETTLE_TICKS   = 2'd2,
        CFG_DEBOUNCE_LIMIT = 2'd3
    } t_cfg_index;

    // Digit positions, left to right
    localparam logic [DIGIT_W-1:0] DIGIT_LEFT  = 2'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_MID   = 2'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_RIGHT = 2'd2;

    // Special glyphs
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
    localparam logic [SEG_W-1:0] SEG_E     = 7'h79;
    localparam logic [SEG_W-1:0] SEG_R     = 7'h50;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_count;
        logic               button_level;
    } t_in_item;

    typedef struct packed {
        logic [SEG_W-1:0]   segment_bits;
        logic [SEL_W-1:0]   digit_select;
        logic [VALUE_W-1:0] shown_value;
        logic               button_down;
    } t_out_item;

    // Decimal digit to segments a..g, bit0 = a
    function automatic logic [SEG_W-1:0] f_seg_digit(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/event_counter_display_driver_top.sv -----
// ----------------------------------------------------------------------------
// event_counter_display_driver_top: event counter with settled 3-digit display
// Debounced clear, limited event count, settling delay on the shown value and
// a multiplexed seven-segment digit output, one display tick per input beat.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Beat
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | i_in_valid/o_in_stall | t_in_item  (pulses, button)
//  out     | output    | o_out_valid/i_out_stall| t_out_item (segments, select,
//          |           |                       |             value, button)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| index + 16-bit data
//
//  One beat per clock cycle unless the output stalls; each result goes through both stages.
//  Stage 1 updates the counter, settling and debounce state; stage 2 is the
//  output register fed by the decimal split and glyph decode.
//  A stall on a full output register freezes both stages and stalls the input.
//  Reset is synchronous; it sets all state but the stage 1 and output payloads.
// ----------------------------------------------------------------------------
module event_counter_display_driver_top
    import ecdd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [LIMIT_W-1:0] r_limit;
    logic [TICKS_W-1:0] r_settle_ticks;
    logic [TICKS_W-1:0] r_deb_limit;

    // Block state
    logic [VALUE_W-1:0] r_event;
    logic [VALUE_W-1:0] r_shown;
    logic [TICKS_W-1:0] r_settle_cnt;
    logic [DIGIT_W-1:0] r_digit;
    logic [TICKS_W-1:0] r_integral;
    logic               r_pressed;

    // Stage 1 and output register
    logic               r_s1_valid;
    logic [VALUE_W-1:0] r_s1_shown;
    logic [DIGIT_W-1:0] r_s1_digit;
    logic               r_s1_down;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_advance;
    logic               w_in_accept;
    logic               w_cfg_write;
    t_cfg_index         w_cfg_index;
    logic [VALUE_W-1:0] w_base;
    logic [VALUE_W-1:0] w_sum;
    logic [VALUE_W-1:0] n_event;
    logic [VALUE_W-1:0] n_shown;
    logic [TICKS_W-1:0] n_settle_cnt;
    logic [TICKS_W-1:0] w_settle_inc;
    logic [DIGIT_W-1:0] n_digit;
    logic [TICKS_W-1:0] n_integral;
    logic               n_pressed;
    logic [SEG_W-1:0]   w_segments;

    // Pipeline moves unless the output holds a beat that is stalled
    assign w_advance   = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_advance;
    assign w_in_accept = i_in_valid && w_advance;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign w_cfg_index = t_cfg_index'(i_cfg_index);

    // Clear on a press held before this tick, add pulses, wrap past the limit
    always_comb begin
        w_base  = r_pressed ? '0 : r_event;
        w_sum   = w_base + VALUE_W'(i_in_data.pulse_count);
        n_event = (w_sum > VALUE_W'(r_limit)) ? '0 : w_sum;
    end

    // Settle: copy the count once it has differed long enough
    always_comb begin
        w_settle_inc = r_settle_cnt + 8'd1;
        n_shown      = r_shown;
        if (n_event != r_shown) begin
            n_settle_cnt = w_settle_inc;
            if (w_settle_inc >= r_settle_ticks) begin
                n_shown = n_event;
            end
        end else begin
            n_settle_cnt = '0;
        end
    end

    // Advance the digit index mod 3
    assign n_digit = (r_digit >= DIGIT_RIGHT) ? DIGIT_LEFT : r_digit + 2'd1;

    // Debounce integrator, saturating at the limit
    always_comb begin
        n_integral = r_integral;
        n_pressed  = r_pressed;
        if (i_in_data.button_level) begin
            if (r_integral < r_deb_limit) begin
                n_integral = r_integral + 8'd1;
            end
            if (n_integral >= r_deb_limit) begin
                n_pressed = 1'b1;
            end
        end else begin
            if (r_integral != '0) begin
                n_integral = r_integral - 8'd1;
            end
            if (n_integral == '0) begin
                n_pressed = 1'b0;
            end
        end
    end

    // Configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit        <= 10'd999;
            r_settle_ticks <= 8'd255;
            r_deb_limit    <= 8'd255;
            r_event        <= '0;
            r_shown        <= '0;
            r_settle_cnt   <= '0;
            r_digit        <= DIGIT_LEFT;
            r_integral     <= '0;
            r_pressed      <= 1'b0;
        end else if (w_cfg_write) begin
            unique case (w_cfg_index)
                CFG_START_COUNT: begin
                    r_event      <= i_cfg_data;
                    r_shown      <= i_cfg_data;
                    r_settle_cnt <= '0;
                end
                CFG_COUNT_LIMIT:    r_limit        <= i_cfg_data[LIMIT_W-1:0];
                CFG_SETTLE_TICKS:   r_settle_ticks <= i_cfg_data[TICKS_W-1:0];
                CFG_DEBOUNCE_LIMIT: r_deb_limit    <= i_cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end else if (w_in_accept) begin
            r_event      <= n_event;
            r_shown      <= n_shown;
            r_settle_cnt <= n_settle_cnt;
            r_digit      <= n_digit;
            r_integral   <= n_integral;
            r_pressed    <= n_pressed;
        end
    end

    // Stage 1 valid and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_shown <= n_shown;
            r_s1_digit <= n_digit;
            r_s1_down  <= n_pressed;
        end
    end

    ecdd_seg_decode u_seg_decode (
        .i_value    (r_s1_shown),
        .i_digit    (r_s1_digit),
        .o_segments (w_segments)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_out.segment_bits <= w_segments;
            r_out.digit_select <= SEL_W'(3'b001 << r_s1_digit);
            r_out.shown_value  <= r_s1_shown;
            r_out.button_down  <= r_s1_down;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Input is only held back by a full, stalled output register
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    // An accepted beat reaches stage 1 on the next edge
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_s1_valid)
        else $error("accepted beat lost before stage 1");

    // Digit select is one-hot on every delivered beat
    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_out_data.digit_select))
        else $error("digit select not one-hot");

    // Digit index never rests on the unused code
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit == DIGIT_LEFT || r_digit == DIGIT_MID || r_digit == DIGIT_RIGHT)
        else $error("digit index out of range");

endmodule

// ----- rtl/ecdd_seg_decode.sv -----
// ----------------------------------------------------------------------------
// ecdd_seg_decode: shown value to one digit's segment pattern
// Splits a value below one thousand into hundreds, tens and units by
// reciprocal multiplication, blanks leading zeros and shows "Err" on overflow.
// ----------------------------------------------------------------------------
module ecdd_seg_decode
    import ecdd_pkg::*;
(
    input  logic [VALUE_W-1:0] i_value,
    input  logic [DIGIT_W-1:0] i_digit,
    output logic [SEG_W-1:0]   o_segments
);

    logic [LIMIT_W-1:0] w_v10;
    logic               w_over;
    logic [22:0]        w_hund_prod;
    logic [3:0]         w_hund;
    logic [17:0]        w_q10_prod;
    logic [6:0]         w_q10;
    logic [6:0]         w_hund_x10;
    logic [6:0]         w_tens_full;
    logic [3:0]         w_tens;
    logic [LIMIT_W-1:0] w_q10_x10;
    logic [LIMIT_W-1:0] w_units_full;
    logic [3:0]         w_units;
    logic [SEG_W-1:0]   w_pat_left;
    logic [SEG_W-1:0]   w_pat_mid;
    logic [SEG_W-1:0]   w_pat_right;

    // Only the low ten bits matter once overflow is ruled out
    assign w_v10  = i_value[LIMIT_W-1:0];
    assign w_over = (i_value > DISPLAY_MAX);

    // Hundreds: v / 100 = (v * 5243) >> 19, exact for v below 1024
    assign w_hund_prod = 23'(w_v10) * 23'd5243;
    assign w_hund      = w_hund_prod[22:19];

    // v / 10 = (v * 205) >> 11, exact for v below 1024
    assign w_q10_prod = 18'(w_v10) * 18'd205;
    assign w_q10      = w_q10_prod[17:11];

    // Tens and units from the quotients
    assign w_hund_x10   = 7'(w_hund) * 7'd10;
    assign w_tens_full  = w_q10 - w_hund_x10;
    assign w_tens       = w_tens_full[3:0];
    assign w_q10_x10    = 10'(w_q10) * 10'd10;
    assign w_units_full = w_v10 - w_q10_x10;
    assign w_units      = w_units_full[3:0];

    // Build the three glyphs with leading-zero blanking
    always_comb begin
        if (w_over) begin
            w_pat_left  = SEG_E;
            w_pat_mid   = SEG_R;
            w_pat_right = SEG_R;
        end else begin
            w_pat_left  = (w_hund == 4'd0) ? SEG_BLANK : f_seg_digit(w_hund);
            w_pat_mid   = (w_hund == 4'd0 && w_tens == 4'd0) ? SEG_BLANK
                                                             : f_seg_digit(w_tens);
            w_pat_right = f_seg_digit(w_units);
        end
    end

    // Pick the active digit
    always_comb begin
        unique case (i_digit)
            DIGIT_LEFT:  o_segments = w_pat_left;
            DIGIT_MID:   o_segments = w_pat_mid;
            DIGIT_RIGHT: o_segments = w_pat_right;
            default:     o_segments = w_pat_left;
        endcase
    end

endmodule
